// ===== rtl/t9kp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// t9kp_pkg
// shared types, key codes and letter tables of the t9 keypad word predictor
// ----------------------------------------------------------------------------
package t9kp_pkg;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_KEY   = 2'd1;
   localparam logic [1:0] MODE_FLUSH = 2'd2;

   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_TWO   = 8'h32;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PERIOD = 8'h2E;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_QUEST  = 8'h3F;

   localparam logic [15:0] FREQ_MAX = 16'hFFFF;
   localparam logic [4:0]  CODE_SAT = 5'd31;

   // decoded key press
   typedef struct packed {
      logic       is_digit;
      logic       is_one;
      logic       is_space;
      logic       is_star;
      logic [2:0] key;
   } key_dec_type;

   // letters of keys 2..9: first letter and letter count
   function automatic logic letter_on_key(input logic [7:0] letter, input logic [2:0] key);
      logic [7:0] first;
      logic [7:0] count;
      begin
         first = 8'h61;
         count = 8'd3;
         case (key)
            3'd0: first = 8'h61;
            3'd1: first = 8'h64;
            3'd2: first = 8'h67;
            3'd3: first = 8'h6A;
            3'd4: first = 8'h6D;
            3'd5: begin
               first = 8'h70;
               count = 8'd4;
            end
            3'd6: first = 8'h74;
            default: begin
               first = 8'h77;
               count = 8'd4;
            end
         endcase
         letter_on_key = (letter >= first) && (letter < first + count);
      end
   endfunction

   function automatic logic [7:0] mark_char(input logic [1:0] idx);
      logic [7:0] c;
      begin
         case (idx)
            2'd1: c = CH_COMMA;
            2'd2: c = CH_QUEST;
            default: c = CH_PERIOD;
         endcase
         mark_char = c;
      end
   endfunction

endpackage
`default_nettype wire

// ===== rtl/t9kp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// t9kp channel interfaces
// valid/ready channels for key and load transactions and for text output
// ----------------------------------------------------------------------------
interface t9kp_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [7:0]  symbol;
   logic        word_end;
   logic [15:0] frequency;

   modport source (output valid, output mode, output symbol, output word_end,
                   output frequency, input ready);
   modport sink   (input valid, input mode, input symbol, input word_end,
                   input frequency, output ready);
endinterface

interface t9kp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_char;
   logic       last;

   modport source (output valid, output out_char, output last, input ready);
   modport sink   (input valid, input out_char, input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/t9kp_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// t9kp_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module t9kp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/t9kp_key_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// t9kp_key_decode
// classifies a key press symbol and maps digits 2..9 to a key index
// ----------------------------------------------------------------------------
module t9kp_key_decode (
   input  wire logic [7:0]           symbol,
   output t9kp_pkg::key_dec_type     dec
);
   import t9kp_pkg::*;

   logic [7:0] offset;

   assign offset       = symbol - CH_TWO;
   assign dec.is_digit = (symbol >= CH_TWO) && (symbol <= CH_NINE);
   assign dec.is_one   = (symbol == CH_ONE);
   assign dec.is_space = (symbol == CH_SPACE);
   assign dec.is_star  = (symbol == CH_STAR);
   assign dec.key      = offset[2:0];
endmodule
`default_nettype wire

// ===== rtl/t9_keypad_word_predictor_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// t9_keypad_word_predictor_unit
// t9 predictive text: dictionary load, key code ranking, word and mark commit
// ----------------------------------------------------------------------------
// sequencing: load and digit transactions complete in the idle state, a first
//   digit after a pending choice also runs its commit; a ranking key scans every
//   stored word letter by letter and inserts a match, shifting beaten ones down
// throughput: one transaction at a time; when the output side keeps up, a commit
//   emits one char per cycle after word lookup in C_START, C_W, C_RD and C_LEN
// reset: synchronous, clears counters and flags; no memory clearing pass
// ----------------------------------------------------------------------------
module t9_keypad_word_predictor_unit #(
   parameter int WORDS       = 1024,
   parameter int MAX_LETTERS = 20
) (
   input  wire logic   clock,
   input  wire logic   reset,
   t9kp_req_if.sink    req_bus,
   t9kp_rsp_if.source  rsp_bus
);
   import t9kp_pkg::*;

   // widths
   localparam int IW = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int CW = ($clog2(WORDS + 1) > 2) ? $clog2(WORDS + 1) : 2;
   localparam int LD = WORDS * MAX_LETTERS;
   localparam int LW = (LD > 1) ? $clog2(LD) : 1;
   localparam int KW = (MAX_LETTERS > 1) ? $clog2(MAX_LETTERS) : 1;
   localparam int EW = 16 + 32 + IW;

   localparam logic [CW-1:0] WORDS_C = CW'(WORDS);
   localparam logic [4:0]    MAX_L5  = 5'(MAX_LETTERS);
   localparam logic [LW-1:0] MAX_LW  = LW'(MAX_LETTERS);

   // sequencer states
   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_RW_RD   = 5'd1;
   localparam logic [4:0] ST_RW_CHK  = 5'd2;
   localparam logic [4:0] ST_RL      = 5'd3;
   localparam logic [4:0] ST_INS_RD  = 5'd4;
   localparam logic [4:0] ST_INS_CHK = 5'd5;
   localparam logic [4:0] ST_RDONE   = 5'd6;
   localparam logic [4:0] ST_C_START = 5'd7;
   localparam logic [4:0] ST_C_W     = 5'd8;
   localparam logic [4:0] ST_C_RD    = 5'd9;
   localparam logic [4:0] ST_C_LEN   = 5'd10;
   localparam logic [4:0] ST_C_EMIT  = 5'd11;
   localparam logic [4:0] ST_C_PUNCT = 5'd12;
   localparam logic [4:0] ST_C_UPD   = 5'd13;
   localparam logic [4:0] ST_SPACE   = 5'd14;
   localparam logic [4:0] ST_FINAL   = 5'd15;

   // control registers
   logic [4:0]    state_ff, state_in;
   logic [CW-1:0] word_count_ff, word_count_in;
   logic [4:0]    load_pos_ff, load_pos_in;
   logic [LW-1:0] load_base_ff, load_base_in;
   logic [CW-1:0] cand_ff, cand_in;
   logic [4:0]    code_len_ff, code_len_in;
   logic          typing_ff, typing_in;
   logic          punct_ff, punct_in;
   logic          valid_ff, valid_in;
   logic [CW-1:0] cidx_ff, cidx_in;
   logic [31:0]   counter_ff, counter_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // working registers
   logic [1:0]    mode_ff, mode_in;
   key_dec_type   dec_ff, dec_in;
   logic [CW-1:0] i_ff, i_in;
   logic [LW-1:0] base_i_ff, base_i_in;
   logic [4:0]    j_ff, j_in;
   logic [CW-1:0] p_ff, p_in;
   logic [15:0]   nfreq_ff, nfreq_in;
   logic [31:0]   nrec_ff, nrec_in;
   logic [IW-1:0] w_ff, w_in;
   logic [LW-1:0] base_w_ff, base_w_in;
   logic [4:0]    k_ff, k_in;
   logic [4:0]    len_ff, len_in;
   logic [15:0]   cfreq_ff, cfreq_in;
   logic [7:0]    rsp_char_ff, rsp_char_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [2:0]    key_ff [MAX_LETTERS];

   // key code store write
   logic          key_we;
   logic [KW-1:0] key_widx;

   // memory ports
   logic          let_we;
   logic [LW-1:0] let_waddr, let_raddr;
   logic [7:0]    let_rd;
   logic          len_we;
   logic [IW-1:0] len_waddr, len_raddr;
   logic [4:0]    len_wdata, len_rd;
   logic          freq_we;
   logic [IW-1:0] freq_waddr;
   logic [15:0]   freq_wdata, freq_rd;
   logic          rec_we;
   logic [IW-1:0] rec_waddr;
   logic [31:0]   rec_wdata, rec_rd;
   logic          rank_we;
   logic [IW-1:0] rank_waddr, rank_raddr;
   logic [EW-1:0] rank_wdata, rank_rd;

   // output slot and emit request
   logic       slot_free;
   logic       emit_en;
   logic [7:0] emit_char;
   logic       emit_last;

   logic          accept;
   key_dec_type   req_dec;
   logic [15:0]   e_freq;
   logic [31:0]   e_rec;
   logic [IW-1:0] e_idx;
   logic [IW-1:0] w_safe;
   logic          beats;
   logic          let_match;
   logic          word_done;
   logic          want_commit;
   logic          want_space;
   logic [4:0]    pos_next;

   t9kp_key_decode u_decode (
      .symbol (req_bus.symbol),
      .dec    (req_dec)
   );

   // dictionary letters, one row of MAX_LETTERS per word
   t9kp_ram #(.WIDTH(8), .DEPTH(LD)) u_letters (
      .clock(clock), .wr_en(let_we), .wr_addr(let_waddr), .wr_data(req_bus.symbol),
      .rd_addr(let_raddr), .rd_data(let_rd)
   );
   t9kp_ram #(.WIDTH(5), .DEPTH(WORDS)) u_length (
      .clock(clock), .wr_en(len_we), .wr_addr(len_waddr), .wr_data(len_wdata),
      .rd_addr(len_raddr), .rd_data(len_rd)
   );
   t9kp_ram #(.WIDTH(16), .DEPTH(WORDS)) u_freq (
      .clock(clock), .wr_en(freq_we), .wr_addr(freq_waddr), .wr_data(freq_wdata),
      .rd_addr(len_raddr), .rd_data(freq_rd)
   );
   t9kp_ram #(.WIDTH(32), .DEPTH(WORDS)) u_recency (
      .clock(clock), .wr_en(rec_we), .wr_addr(rec_waddr), .wr_data(rec_wdata),
      .rd_addr(len_raddr), .rd_data(rec_rd)
   );
   // ranking: {frequency, recency, word index}, best first
   t9kp_ram #(.WIDTH(EW), .DEPTH(WORDS)) u_ranking (
      .clock(clock), .wr_en(rank_we), .wr_addr(rank_waddr), .wr_data(rank_wdata),
      .rd_addr(rank_raddr), .rd_data(rank_rd)
   );

   assign req_bus.ready    = (state_ff == ST_IDLE);
   assign accept           = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.out_char = rsp_char_ff;
   assign rsp_bus.last     = rsp_last_ff;
   assign slot_free        = !rsp_valid_ff || rsp_bus.ready;

   assign e_freq = rank_rd[EW-1 -: 16];
   assign e_rec  = rank_rd[IW +: 32];
   assign e_idx  = rank_rd[IW-1:0];
   assign w_safe = (CW'(e_idx) >= WORDS_C) ? '0 : e_idx;

   // new word outranks a stored candidate: strictly better frequency, then recency
   assign beats = (nfreq_ff > e_freq) || ((nfreq_ff == e_freq) && (nrec_ff > e_rec));

   // what follows ranking, from the transaction held in mode_ff/dec_ff
   assign want_commit = (mode_ff == MODE_FLUSH) ||
                        ((mode_ff == MODE_KEY) && (dec_ff.is_one || dec_ff.is_space ||
                                                   dec_ff.is_digit));
   assign want_space  = (mode_ff == MODE_KEY) && dec_ff.is_space;

   assign pos_next = (load_pos_ff < MAX_L5) ? load_pos_ff + 5'd1 : load_pos_ff;

   // letter of the current word on key j
   assign let_match = letter_on_key(let_rd, key_ff[j_ff[KW-1:0]]);
   assign word_done = (i_ff + 1'b1 == word_count_ff);

   always_comb begin
      state_in      = state_ff;
      word_count_in = word_count_ff;
      load_pos_in   = load_pos_ff;
      load_base_in  = load_base_ff;
      cand_in       = cand_ff;
      code_len_in   = code_len_ff;
      typing_in     = typing_ff;
      punct_in      = punct_ff;
      valid_in      = valid_ff;
      cidx_in       = cidx_ff;
      counter_in    = counter_ff;
      mode_in       = mode_ff;
      dec_in        = dec_ff;
      i_in          = i_ff;
      base_i_in     = base_i_ff;
      j_in          = j_ff;
      p_in          = p_ff;
      nfreq_in      = nfreq_ff;
      nrec_in       = nrec_ff;
      w_in          = w_ff;
      base_w_in     = base_w_ff;
      k_in          = k_ff;
      len_in        = len_ff;
      cfreq_in      = cfreq_ff;

      key_we     = 1'b0;
      key_widx   = code_len_ff[KW-1:0];
      let_we     = 1'b0;
      let_waddr  = load_base_ff + LW'(load_pos_ff);
      let_raddr  = base_i_ff;
      len_we     = 1'b0;
      len_waddr  = word_count_ff[IW-1:0];
      len_wdata  = pos_next;
      len_raddr  = i_ff[IW-1:0];
      freq_we    = 1'b0;
      freq_waddr = word_count_ff[IW-1:0];
      freq_wdata = req_bus.frequency;
      rec_we     = 1'b0;
      rec_waddr  = word_count_ff[IW-1:0];
      rec_wdata  = '0;
      rank_we    = 1'b0;
      rank_waddr = p_ff[IW-1:0];
      rank_wdata = {nfreq_ff, nrec_ff, i_ff[IW-1:0]};
      rank_raddr = IW'(p_ff - 1'b1);

      emit_en   = 1'b0;
      emit_char = CH_SPACE;
      emit_last = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in = req_bus.mode;
               dec_in  = req_dec;
               case (req_bus.mode)
                  MODE_LOAD: begin
                     // store full: ignore further letters and words
                     if (word_count_ff < WORDS_C) begin
                        let_we      = (load_pos_ff < MAX_L5);
                        load_pos_in = pos_next;
                        if (req_bus.word_end) begin
                           len_we        = 1'b1;
                           freq_we       = 1'b1;
                           rec_we        = 1'b1;
                           word_count_in = word_count_ff + 1'b1;
                           load_pos_in   = '0;
                           load_base_in  = load_base_ff + MAX_LW;
                        end
                     end
                  end
                  MODE_KEY: begin
                     if (req_dec.is_digit) begin
                        if (!typing_ff) begin
                           // first digit of a new code commits the pending choice
                           typing_in   = 1'b1;
                           code_len_in = 5'd1;
                           key_we      = 1'b1;
                           key_widx    = '0;
                           if (valid_ff) begin
                              state_in = ST_C_START;
                           end
                        end else begin
                           key_we = (code_len_ff < MAX_L5);
                           if (code_len_ff < CODE_SAT) begin
                              code_len_in = code_len_ff + 5'd1;
                           end
                        end
                     end else if (typing_ff) begin
                        i_in      = '0;
                        base_i_in = '0;
                        cand_in   = '0;
                        state_in  = (word_count_ff == '0) ? ST_RDONE : ST_RW_RD;
                     end else if (req_dec.is_one || req_dec.is_space) begin
                        state_in = ST_C_START;
                     end else begin
                        state_in = ST_FINAL;
                     end
                  end
                  MODE_FLUSH: begin
                     if (!valid_ff && typing_ff) begin
                        i_in      = '0;
                        base_i_in = '0;
                        cand_in   = '0;
                        state_in  = (word_count_ff == '0) ? ST_RDONE : ST_RW_RD;
                     end else begin
                        state_in = ST_C_START;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // ranking scan: length, frequency, recency and first letter of word i
         ST_RW_RD: begin
            let_raddr = base_i_ff;
            state_in  = ST_RW_CHK;
         end
         ST_RW_CHK: begin
            let_raddr = base_i_ff + LW'(1);
            nfreq_in  = freq_rd;
            nrec_in   = rec_rd;
            j_in      = 5'd1;
            if ((len_rd == code_len_ff) &&
                letter_on_key(let_rd, key_ff[0])) begin
               state_in = (len_rd == 5'd1) ? ST_INS_RD : ST_RL;
               p_in     = cand_ff;
            end else if (word_done) begin
               state_in = ST_RDONE;
            end else begin
               i_in      = i_ff + 1'b1;
               base_i_in = base_i_ff + MAX_LW;
               state_in  = ST_RW_RD;
            end
         end
         ST_RL: begin
            let_raddr = base_i_ff + LW'({1'b0, j_ff} + 6'd1);
            if (!let_match) begin
               if (word_done) begin
                  state_in = ST_RDONE;
               end else begin
                  i_in      = i_ff + 1'b1;
                  base_i_in = base_i_ff + MAX_LW;
                  state_in  = ST_RW_RD;
               end
            end else if (j_ff + 5'd1 == code_len_ff) begin
               state_in = ST_INS_RD;
            end else begin
               j_in = j_ff + 5'd1;
            end
         end

         // insertion walks up from the end of the ranking
         ST_INS_RD: begin
            rank_raddr = IW'(p_ff - 1'b1);
            if (p_ff == '0) begin
               rank_we = 1'b1;
               cand_in = cand_ff + 1'b1;
               if (word_done) begin
                  state_in = ST_RDONE;
               end else begin
                  i_in      = i_ff + 1'b1;
                  base_i_in = base_i_ff + MAX_LW;
                  state_in  = ST_RW_RD;
               end
            end else begin
               state_in = ST_INS_CHK;
            end
         end
         ST_INS_CHK: begin
            rank_we = 1'b1;
            if (beats) begin
               // shift the beaten candidate down one slot
               rank_wdata = rank_rd;
               p_in       = p_ff - 1'b1;
               state_in   = ST_INS_RD;
            end else begin
               cand_in = cand_ff + 1'b1;
               if (word_done) begin
                  state_in = ST_RDONE;
               end else begin
                  i_in      = i_ff + 1'b1;
                  base_i_in = base_i_ff + MAX_LW;
                  state_in  = ST_RW_RD;
               end
            end
         end
         ST_RDONE: begin
            typing_in = 1'b0;
            if (cand_ff != '0) begin
               valid_in = 1'b1;
               cidx_in  = '0;
            end
            state_in = want_commit ? ST_C_START : ST_FINAL;
         end

         // commit of the pending choice
         ST_C_START: begin
            rank_raddr = (cidx_ff < WORDS_C) ? IW'(cidx_ff) : '0;
            if (!valid_ff) begin
               state_in = want_space ? ST_SPACE : ST_FINAL;
            end else if (punct_ff) begin
               state_in = ST_C_PUNCT;
            end else begin
               state_in = ST_C_W;
            end
         end
         ST_C_W: begin
            w_in      = w_safe;
            base_w_in = LW'(w_safe) * MAX_LW;
            state_in  = ST_C_RD;
         end
         ST_C_RD: begin
            len_raddr = w_ff;
            let_raddr = base_w_ff;
            state_in  = ST_C_LEN;
         end
         ST_C_LEN: begin
            len_in    = len_rd;
            cfreq_in  = freq_rd;
            k_in      = '0;
            let_raddr = base_w_ff;
            state_in  = (len_rd == '0) ? ST_C_UPD : ST_C_EMIT;
         end
         ST_C_EMIT: begin
            let_raddr = slot_free ? base_w_ff + LW'({1'b0, k_ff} + 6'd1)
                                  : base_w_ff + LW'(k_ff);
            if (slot_free) begin
               emit_en   = 1'b1;
               emit_char = let_rd;
               emit_last = (k_ff + 5'd1 == len_ff) && !want_space;
               if (k_ff + 5'd1 == len_ff) begin
                  state_in = ST_C_UPD;
               end else begin
                  k_in = k_ff + 5'd1;
               end
            end
         end
         ST_C_PUNCT: begin
            if (slot_free) begin
               emit_en   = 1'b1;
               emit_char = mark_char((cidx_ff < CW'(3)) ? cidx_ff[1:0] : 2'd0);
               emit_last = !want_space;
               punct_in  = 1'b0;
               valid_in  = 1'b0;
               state_in  = want_space ? ST_SPACE : ST_FINAL;
            end
         end
         ST_C_UPD: begin
            freq_we    = 1'b1;
            freq_waddr = w_ff;
            freq_wdata = (cfreq_ff == FREQ_MAX) ? cfreq_ff : cfreq_ff + 16'd1;
            rec_we     = 1'b1;
            rec_waddr  = w_ff;
            rec_wdata  = counter_ff;
            counter_in = counter_ff + 32'd1;
            cand_in    = '0;
            valid_in   = 1'b0;
            state_in   = want_space ? ST_SPACE : ST_FINAL;
         end
         ST_SPACE: begin
            if (slot_free) begin
               emit_en  = 1'b1;
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            if ((mode_ff == MODE_KEY) && dec_ff.is_one) begin
               // start cycling over the punctuation marks
               punct_in = 1'b1;
               valid_in = 1'b1;
               cidx_in  = '0;
               cand_in  = CW'(3);
            end else if ((mode_ff == MODE_KEY) && dec_ff.is_star && valid_ff) begin
               cidx_in = (cidx_ff + 1'b1 >= cand_ff) ? '0 : cidx_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_en) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         word_count_ff <= '0;
         load_pos_ff   <= '0;
         load_base_ff  <= '0;
         cand_ff       <= '0;
         code_len_ff   <= '0;
         typing_ff     <= 1'b0;
         punct_ff      <= 1'b0;
         valid_ff      <= 1'b0;
         cidx_ff       <= '0;
         counter_ff    <= 32'd1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         word_count_ff <= word_count_in;
         load_pos_ff   <= load_pos_in;
         load_base_ff  <= load_base_in;
         cand_ff       <= cand_in;
         code_len_ff   <= code_len_in;
         typing_ff     <= typing_in;
         punct_ff      <= punct_in;
         valid_ff      <= valid_in;
         cidx_ff       <= cidx_in;
         counter_ff    <= counter_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      dec_ff      <= dec_in;
      i_ff        <= i_in;
      base_i_ff   <= base_i_in;
      j_ff        <= j_in;
      p_ff        <= p_in;
      nfreq_ff    <= nfreq_in;
      nrec_ff     <= nrec_in;
      w_ff        <= w_in;
      base_w_ff   <= base_w_in;
      k_ff        <= k_in;
      len_ff      <= len_in;
      cfreq_ff    <= cfreq_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (key_we) begin
         key_ff[key_widx] <= req_dec.key;
      end
   end

   // a pending word choice always points inside the ranking
   a_choice_in_range: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !punct_ff) |-> (cidx_ff < cand_ff))
      else $error("choice index beyond candidate count");

   // letters are only emitted inside the word
   a_emit_in_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_C_EMIT) |-> (k_ff < len_ff))
      else $error("letter emit beyond word length");

   // shifting never walks above the top of the ranking
   a_shift_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_CHK) |-> (p_ff != '0 && p_ff <= cand_ff))
      else $error("ranking shift out of range");

   // no candidate survives a word commit
   a_commit_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_C_UPD) |=> (cand_ff == '0 && !valid_ff))
      else $error("commit left a pending choice");

endmodule
`default_nettype wire
